/* rtl/first_fit_range_allocator_core_macros.svh */
// assertion macros for the free range allocator
`ifndef FIRST_FIT_RANGE_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define FFRA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ffra_pkg.sv */
// shared types, codes and helpers of the free range allocator
package ffra_pkg;

  localparam int unsigned MaxFreeRangesDef = 32;
  localparam int unsigned BufferCount      = 2;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_BAD_SIZE   = 3'd1,
    STS_FRAGMENTED = 3'd2,
    STS_NO_SPACE   = 3'd3,
    STS_LIST_FULL  = 3'd4
  } status_e;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_len(input logic [32:0] x);
    return x[32] ? 32'hFFFF_FFFF : x[31:0];
  endfunction

endpackage

/* rtl/ffra_list_ram.sv */
// two-bank range list memory, one write and one registered read port
module ffra_list_ram #(
  parameter int unsigned AW = 6
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  ffra_pkg::entry_t       wdata_i,
  input  logic [AW-1:0]          raddr_i,
  output ffra_pkg::entry_t       rdata_o
);
  import ffra_pkg::*;

  entry_t mem_q [2**AW];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/first_fit_range_allocator_core.sv */
// first-fit free range allocator: each alloc, free or no-op item walks the range list once,
// reading then processing each stored range, streaming a rewritten copy into the spare bank
// of the list memory and switching banks at the end unless a free overflows the list (a free
// also inserts and flushes the merged range); a clear writes only the configured range. The
// list memory has a single read port. The block takes no new item until the current one is done.
`include "first_fit_range_allocator_core_macros.svh"

module first_fit_range_allocator_core #(
  parameter int unsigned MAX_FREE_RANGES = ffra_pkg::MaxFreeRangesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [23:0] payload_size_i,
  input  logic [31:0] range_offset_i,
  input  logic [31:0] range_size_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] block_offset_o,
  output logic [31:0] block_size_o,
  output logic [31:0] total_free_o
);
  import ffra_pkg::*;

  localparam int unsigned IW = $clog2(MAX_FREE_RANGES);
  localparam int unsigned AW = IW + 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned WW = IW + 2;
  localparam logic [CW-1:0] NCnt = CW'(MAX_FREE_RANGES);
  localparam logic [WW-1:0] NWr  = WW'(MAX_FREE_RANGES);
  localparam logic [32:0]   TopEnd = 33'h1_0000_0000;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_PROC, S_TAIL, S_FLUSH, S_CLR, S_FIN
  } state_e;

  state_e        state_q, state_d;
  logic          merge_q, merge_d;
  logic          alloc_en_q, alloc_en_d;
  logic          bad_q, bad_d;
  logic [31:0]   need_q, need_d;
  logic [31:0]   off_q, off_d;
  logic [32:0]   end_q, end_d;
  logic          placed_q, placed_d;
  logic          found_q, found_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [WW-1:0] wcnt_q, wcnt_d;
  logic          pv_q, pv_d;
  logic [31:0]   ps_q, ps_d;
  logic [32:0]   pe_q, pe_d;
  logic [31:0]   osum_q, osum_d;
  logic [31:0]   nsum_q, nsum_d;
  logic [31:0]   boff_q, boff_d;
  logic          bank_q, bank_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   base_q, base_d;
  logic [31:0]   size_q, size_d;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    status_q, status_d;
  logic [31:0]   bo_q, bo_d;
  logic [31:0]   bs_q, bs_d;
  logic [31:0]   tf_q, tf_d;

  logic          accept;
  logic          cfg_we;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  entry_t        rd;
  logic [32:0]   rd_end;
  logic [24:0]   rnd;
  logic [32:0]   room;
  logic [32:0]   clen;
  logic [32:0]   croom;
  logic [32:0]   clr_len;
  logic          take_new;
  logic [31:0]   cs;
  logic [32:0]   ce;
  logic          emit;
  logic          full;
  logic          fit;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_we     = psel && penable && pwrite;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_SIZE) ? size_q : base_q;

  assign rd_end  = {1'b0, rd.start} + {1'b0, rd.length};
  assign rnd     = ({1'b0, payload_size_i} + 25'd63) & ~25'd63;
  assign room    = TopEnd - {1'b0, range_offset_i};
  assign clen    = ({1'b0, range_size_i} < room) ? {1'b0, range_size_i} : room;
  assign croom   = TopEnd - {1'b0, base_q};
  assign clr_len = ({1'b0, size_q} < croom) ? {1'b0, size_q} : croom;

  // candidate range for the merge: the freed range slots in before the first higher start
  assign take_new = (state_q == S_TAIL) || (!placed_q && (off_q < rd.start));
  assign cs       = take_new ? off_q : rd.start;
  assign ce       = take_new ? end_q : rd_end;
  assign emit     = pv_q && ((state_q == S_FLUSH) || (pe_q < {1'b0, cs}));
  assign fit      = alloc_en_q && !found_q && (rd.length >= need_q);
  assign full     = merge_q && (wcnt_q > NWr);

  always_comb begin
    state_d     = state_q;
    merge_d     = merge_q;
    alloc_en_d  = alloc_en_q;
    bad_d       = bad_q;
    need_d      = need_q;
    off_d       = off_q;
    end_d       = end_q;
    placed_d    = placed_q;
    found_d     = found_q;
    idx_d       = idx_q;
    wcnt_d      = wcnt_q;
    pv_d        = pv_q;
    ps_d        = ps_q;
    pe_d        = pe_q;
    osum_d      = osum_q;
    nsum_d      = nsum_q;
    boff_d      = boff_q;
    bank_d      = bank_q;
    count_d     = count_q;
    base_d      = base_q;
    size_d      = size_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    bo_d        = bo_q;
    bs_d        = bs_q;
    tf_d        = tf_q;
    we          = 1'b0;
    wdata       = '0;

    if (cfg_we) begin
      if (paddr[2] == REG_SIZE) begin
        size_d = pwdata;
      end else begin
        base_d = pwdata;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          merge_d    = 1'b0;
          alloc_en_d = 1'b0;
          bad_d      = 1'b0;
          need_d     = 32'(32'(rnd) * 32'(BufferCount));
          off_d      = range_offset_i;
          end_d      = {1'b0, range_offset_i} + clen;
          placed_d   = 1'b0;
          found_d    = 1'b0;
          idx_d      = '0;
          wcnt_d     = '0;
          pv_d       = 1'b0;
          osum_d     = '0;
          nsum_d     = '0;
          boff_d     = '0;
          state_d    = S_RD;
          case (opcode_e'(opcode_i))
            OP_ALLOC: begin
              alloc_en_d = (payload_size_i != '0);
              bad_d      = (payload_size_i == '0);
            end
            OP_FREE: begin
              merge_d = (range_size_i != '0);
            end
            OP_CLEAR: begin
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (idx_q == count_q) begin
          if (!merge_q) begin
            state_d = S_FIN;
          end else if (placed_q) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_TAIL;
          end
        end else begin
          state_d = S_PROC;
        end
      end
      S_PROC, S_TAIL, S_FLUSH: begin
        if (merge_q) begin
          if (emit) begin
            we     = 1'b1;
            wdata  = '{start: ps_q, length: sat_len(pe_q - {1'b0, ps_q})};
          end
          if (!pv_q || (pe_q < {1'b0, cs})) begin
            pv_d = 1'b1;
            ps_d = cs;
            pe_d = ce;
          end else if (ce > pe_q) begin
            pe_d = ce;
          end
          if (state_q == S_FLUSH) begin
            state_d = S_FIN;
          end else if (take_new) begin
            placed_d = 1'b1;
            if (state_q == S_TAIL) begin
              state_d = S_FLUSH;
            end
          end else begin
            osum_d  = sat_add(osum_q, rd.length);
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end else begin
          // copy pass, carving the block out of the first range that fits when allocating
          osum_d = sat_add(osum_q, rd.length);
          idx_d  = idx_q + 1'b1;
          if (fit) begin
            found_d = 1'b1;
            boff_d  = rd.start;
            we      = (rd.length != need_q);
            wdata   = '{start: rd.start + need_q, length: rd.length - need_q};
          end else begin
            we    = 1'b1;
            wdata = rd;
          end
          state_d = S_RD;
        end
      end
      S_CLR: begin
        we      = (clr_len != '0);
        wdata   = '{start: base_q, length: clr_len[31:0]};
        state_d = S_FIN;
      end
      S_FIN: begin
        idx_d = '0;
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          bo_d        = found_q ? boff_q : '0;
          bs_d        = found_q ? need_q : '0;
          tf_d        = full ? osum_q : nsum_q;
          if (bad_q) begin
            status_d = STS_BAD_SIZE;
          end else if (full) begin
            status_d = STS_LIST_FULL;
          end else if (alloc_en_q && !found_q) begin
            status_d = (osum_q >= need_q) ? STS_FRAGMENTED : STS_NO_SPACE;
          end else begin
            status_d = STS_OK;
          end
          if (!full) begin
            bank_d  = !bank_q;
            count_d = wcnt_q[CW-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (we) begin
      wcnt_d = wcnt_q + 1'b1;
      nsum_d = sat_add(nsum_q, wdata.length);
    end
  end

  assign waddr = {!bank_q, wcnt_q[IW-1:0]};

  ffra_list_ram #(
    .AW (AW)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (we && (wcnt_q < NWr)),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i ({bank_q, idx_q[IW-1:0]}),
    .rdata_o (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bank_q      <= 1'b0;
      count_q     <= '0;
      base_q      <= '0;
      size_q      <= '0;
      out_valid_q <= 1'b0;
      merge_q     <= 1'b0;
      alloc_en_q  <= 1'b0;
      bad_q       <= 1'b0;
      placed_q    <= 1'b0;
      found_q     <= 1'b0;
      pv_q        <= 1'b0;
      idx_q       <= '0;
      wcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      count_q     <= count_d;
      base_q      <= base_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
      merge_q     <= merge_d;
      alloc_en_q  <= alloc_en_d;
      bad_q       <= bad_d;
      placed_q    <= placed_d;
      found_q     <= found_d;
      pv_q        <= pv_d;
      idx_q       <= idx_d;
      wcnt_q      <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q   <= need_d;
    off_q    <= off_d;
    end_q    <= end_d;
    ps_q     <= ps_d;
    pe_q     <= pe_d;
    osum_q   <= osum_d;
    nsum_q   <= nsum_d;
    boff_q   <= boff_d;
    status_q <= status_d;
    bo_q     <= bo_d;
    bs_q     <= bs_d;
    tf_q     <= tf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign block_offset_o = bo_q;
  assign block_size_o   = bs_q;
  assign total_free_o   = tf_q;

  `FFRA_ASSERT_ALWAYS(a_count_in_range, count_q <= NCnt, "range count beyond capacity")
  `FFRA_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "item accepted but sequencer idle")
  `FFRA_ASSERT_ALWAYS(a_walk_bounded, idx_q <= count_q, "list walk beyond stored ranges")

endmodule

/* verif/first_fit_range_allocator_core_test.sv */
// self-checking testbench for the first-fit free range allocator core
`timescale 1ns / 100ps

module first_fit_range_allocator_core_test;
  import ffra_pkg::*;

  localparam int unsigned NumRanges = 32;
  localparam int unsigned Align     = 64;
  localparam int unsigned WdogLimit = 20000;
  localparam logic [2:0]  AddrBase  = 3'd0;
  localparam logic [2:0]  AddrSize  = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] block_offset;
    logic [31:0] block_size;
    logic [31:0] total_free;
  } alloc_result_t;

  // scoreboard: holds the predicted free list and the expected results
  class alloc_scoreboard;
    logic [31:0] base_q = '0, size_q = '0;
    logic [31:0] rstart [NumRanges];
    logic [31:0] rlen   [NumRanges];
    int unsigned nranges;
    alloc_result_t pending_q[$];
    int unsigned   errors;

    function void set_reg(logic [2:0] addr, logic [31:0] val);
      if (addr == AddrBase) base_q = val;
      else if (addr == AddrSize) size_q = val;
    endfunction

    function logic [31:0] free_sum();
      logic [63:0] t;
      t = 0;
      for (int i = 0; i < nranges; i++) t += rlen[i];
      return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function logic [63:0] clipped(logic [63:0] off, logic [63:0] len);
      logic [63:0] room;
      room = 64'h1_0000_0000 - off;
      return (len < room) ? len : room;
    endfunction

    function logic [2:0] insert_range(logic [63:0] off, logic [63:0] len);
      logic [63:0] s[NumRanges+1], e[NumRanges+1], ms[NumRanges+1], me[NumRanges+1];
      logic [63:0] l;
      int n, m;
      bit placed;
      n = 0; m = 0; placed = 0;
      if (len == 0) return STS_OK;
      len = clipped(off, len);
      for (int i = 0; i < nranges; i++) begin
        if (!placed && off < rstart[i]) begin
          s[n] = off; e[n] = off + len; n++; placed = 1;
        end
        s[n] = rstart[i]; e[n] = 64'(rstart[i]) + rlen[i]; n++;
      end
      if (!placed) begin
        s[n] = off; e[n] = off + len; n++;
      end
      for (int i = 0; i < n; i++) begin
        if (m == 0 || me[m-1] < s[i]) begin
          ms[m] = s[i]; me[m] = e[i]; m++;
        end else if (e[i] > me[m-1]) begin
          me[m-1] = e[i];
        end
      end
      if (m > NumRanges) return STS_LIST_FULL;
      for (int i = 0; i < m; i++) begin
        l = me[i] - ms[i];
        rstart[i] = ms[i][31:0];
        rlen[i] = (l > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : l[31:0];
      end
      nranges = m;
      return STS_OK;
    endfunction

    function void note_item(opcode_e op, logic [23:0] psize, logic [31:0] roff,
                            logic [31:0] rsize);
      alloc_result_t r;
      logic [63:0] need, l;
      int hit;
      r = '0;
      hit = -1;
      case (op)
        OP_ALLOC: begin
          if (psize == 0) begin
            r.status = STS_BAD_SIZE;
          end else begin
            need = (64'(psize) + Align - 1) / Align * Align * BufferCount;
            for (int i = 0; i < nranges; i++)
              if (hit < 0 && rlen[i] >= need) hit = i;
            if (hit >= 0) begin
              r.block_offset = rstart[hit];
              r.block_size = need[31:0];
              rstart[hit] = rstart[hit] + need[31:0];
              rlen[hit] = rlen[hit] - need[31:0];
              if (rlen[hit] == 0) begin
                for (int j = hit; j + 1 < nranges; j++) begin
                  rstart[j] = rstart[j+1]; rlen[j] = rlen[j+1];
                end
                nranges--;
              end
            end else begin
              r.status = (free_sum() >= need) ? STS_FRAGMENTED : STS_NO_SPACE;
            end
          end
        end
        OP_FREE: r.status = insert_range(roff, rsize);
        OP_CLEAR: begin
          l = clipped(base_q, size_q);
          nranges = 0;
          if (l != 0) begin
            rstart[0] = base_q; rlen[0] = l[31:0]; nranges = 1;
          end
        end
        default: ;
      endcase
      r.total_free = free_sum();
      pending_q = {pending_q, r};
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result status=%0d", got.status);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
      end
      if (got.block_offset !== exp_r.block_offset) begin
        $error("block_offset exp %h got %h", exp_r.block_offset, got.block_offset); errors++;
      end
      if (got.block_size !== exp_r.block_size) begin
        $error("block_size exp %h got %h", exp_r.block_size, got.block_size); errors++;
      end
      if (got.total_free !== exp_r.total_free) begin
        $error("total_free exp %h got %h", exp_r.total_free, got.total_free); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [23:0] payload_size_i = '0;
  logic [31:0] range_offset_i = '0, range_size_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] block_offset_o, block_size_o, total_free_o;

  alloc_scoreboard sb = new();
  int unsigned send_idle_pct = 28, recv_idle_pct = 85;
  bit          hold_recv = 1'b0;
  int unsigned quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  first_fit_range_allocator_core u_top (.*);

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      sb.check_result('{status_o, block_offset_o, block_size_o, total_free_o});
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WdogLimit) begin
      $display("first_fit_range_allocator_core_test NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(addr, val);
  endtask

  // valid stays high after an accept until the next idle or drain lowers it
  task automatic send_item(opcode_e op, logic [23:0] psize, logic [31:0] roff,
                           logic [31:0] rsize);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op; payload_size_i <= psize; range_offset_i <= roff; range_size_i <= rsize;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, psize, roff, rsize);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic random_item(logic [31:0] base, logic [31:0] span);
    int unsigned pick;
    logic [31:0] off, len;
    pick = $urandom_range(99);
    off = base + ($urandom_range(span >> 6) << 6);
    len = $urandom_range(8) * 128 + (($urandom_range(3) == 0) ? $urandom_range(63) : 0);
    if (pick < 45)
      send_item(OP_ALLOC, 24'(($urandom_range(9) == 0) ? $urandom : $urandom_range(300)),
                0, 0);
    else if (pick < 85)
      send_item(OP_FREE, 24'($urandom), off, ($urandom_range(19) == 0) ? 32'd0 : len);
    else if (pick < 90)
      send_item(OP_FREE, 24'($urandom), $urandom, $urandom);
    else if (pick < 95)
      send_item(OP_CLEAR, 24'($urandom), $urandom, $urandom);
    else
      send_item(opcode_e'($urandom_range(3)), 24'($urandom), $urandom, $urandom);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty list, edges and opcode corners
    send_item(OP_ALLOC, 24'd1, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0);
    drain();
    write_reg(AddrBase, 32'h0000_1000);
    write_reg(AddrSize, 32'h0000_4000);
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_ALLOC, 24'd0, 0, 0);
    send_item(OP_ALLOC, 24'd1, 0, 0);
    send_item(OP_ALLOC, 24'd64, 0, 0);
    send_item(OP_ALLOC, 24'hFF_FFFF, 0, 0);
    send_item(OP_FREE, 0, 32'h1000, 32'd0);
    send_item(OP_FREE, 0, 32'h1000, 32'd128);
    send_item(OP_FREE, 0, 32'h1040, 32'd256);
    send_item(OP_NOP, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 34; i++) send_item(OP_FREE, 0, 32'h20000 + i * 256, 32'd64);
    send_item(OP_ALLOC, 24'd100, 0, 0);
    send_item(OP_ALLOC, 24'd2000, 0, 0);
    send_item(OP_FREE, 0, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_item(OP_FREE, 0, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 24'hFF_FFFF, 0, 0);
    drain();
    write_reg(AddrBase, 32'hFFFF_FFFF);
    write_reg(AddrSize, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_ALLOC, 24'd1, 0, 0);
    drain();
    write_reg(AddrSize, 32'd0);
    send_item(OP_CLEAR, 0, 0, 0);
    drain();
    // random phases with differing regions and idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 28 : 0;
      write_reg(AddrBase, (ph == 2) ? 32'hFFFF_E000 : $urandom & 32'h0FFF_FFC0);
      write_reg(AddrSize, (ph == 2) ? 32'h0001_0000 : 32'h0000_2000 + $urandom_range(8192));
      send_item(OP_CLEAR, 0, 0, 0);
      if (ph == 1) begin
        fork
          begin
            hold_recv = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_recv = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 310; k++) begin
        random_item(sb.base_q, 32'h0000_4000);
        if (ph == 0 && k == 150) drain();
      end
      drain();
    end
    drain();
    if (sb.errors == 0) $display("first_fit_range_allocator_core_test OK");
    else $display("first_fit_range_allocator_core_test NOT OK");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ffra_pkg.sv
rtl/ffra_list_ram.sv
rtl/first_fit_range_allocator_core.sv
verif/first_fit_range_allocator_core_test.sv
